// File: rtl/core/smm_pkg.sv
// Package for the small matrix multiplier: field widths, action and
// register codes, and the tag word that runs with the multiply-accumulate.
// No dependencies.
`default_nettype none

package smm_pkg;

    // field widths of the channels
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 2;
    localparam int ACT_W     = 2;
    localparam int DIM_W     = 3;
    localparam int CFG_IDX_W = 2;

    // action codes of an input word
    localparam logic [ACT_W-1:0] ACT_LOAD_A  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOAD_B  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_B = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd3;

    // dimension value after reset
    localparam logic [DIM_W-1:0] DIM_RESET = 3'd3;

    // control that travels with one read pair through the mac pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_tag_t;

endpackage

`default_nettype wire

// File: rtl/core/smm_if.sv
// Channel interfaces of the small matrix multiplier: input words,
// result words and configuration writes. Depends on smm_pkg.
`default_nettype none

interface smm_item_if import smm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element;

    modport source (output valid, output action, output row_index,
                    output col_index, output element, input ready);
    modport sink   (input valid, input action, input row_index,
                    input col_index, input element, output ready);
endinterface

interface smm_result_if import smm_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                     dim_error;
    logic                     last;

    modport source (output valid, output out_row, output out_col,
                    output product_value, output dim_error, output last,
                    input ready);
    modport sink   (input valid, input out_row, input out_col,
                    input product_value, input dim_error, input last,
                    output ready);
endinterface

interface smm_cfg_if import smm_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/smm_mem.sv
// Simple dual-port matrix store: one write port, one read port with
// registered read data. Depends on smm_pkg for the data width.
`default_nettype none

module smm_mem import smm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port with registered read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/smm_mac.sv
// Multiply-accumulate pipeline: aligns the tag with the store read data,
// registers the 32-bit wrapped product, then accumulates. Depends on smm_pkg.
`default_nettype none

module smm_mac import smm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mac_tag_t          tag_in,
    input  wire logic [DATA_W-1:0] a_data,
    input  wire logic [DATA_W-1:0] b_data,
    output logic      [DATA_W-1:0] acc,
    output logic                   done
);

    mac_tag_t              tag1_reg;
    mac_tag_t              tag2_reg;
    logic [DATA_W-1:0]     prod_reg;
    logic [DATA_W-1:0]     acc_reg;
    logic [DATA_W-1:0]     acc_next;
    logic                  done_reg;
    logic [DATA_W-1:0]     full_prod;

    // tag stages follow the read latency and the multiplier register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            done_reg <= tag2_reg.valid && tag2_reg.last;
        end
    end

    // low half of the product is the same for signed and unsigned operands
    assign full_prod = a_data * b_data;

    // accumulator starts over on the first term of each element
    always_comb
    begin
        acc_next = acc_reg;
        if (tag2_reg.valid)
        begin
            acc_next = tag2_reg.first ? prod_reg : acc_reg + prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= full_prod;
        acc_reg  <= acc_next;
    end

    assign acc  = acc_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/core/small_matrix_multiply.sv
// Small integer matrix multiplier, top level: configuration registers,
// sequencer, two matrix stores and the result register.
// Depends on smm_pkg, smm_if, smm_mem and smm_mac.
//
// Usage: configure rows_a, cols_a, rows_b, cols_b over cfg (always ready),
// then send load words on item (action 0 for the first matrix, action 1 for
// the second); each in-range load writes one store entry. A compute word
// (action 2) walks the product in row-major order and sends one result word
// per element, last set on the final one. If cols_a and rows_b differ after
// clamping to 1..MAX_DIM, one result word with dim_error set is sent instead.
// Each element issues one store read pair per cycle per inner term, which
// passes through the read register, the multiplier register and the
// accumulator. item stays low while a run is in progress. An element is
// started only when the result register is empty, so a stalled receiver
// simply holds the run; once idle, loads are still taken while the final
// result waits. Reset sets the dimensions to 3 and clears control state;
// store contents are undefined until written.
`default_nettype none

module small_matrix_multiply import smm_pkg::*;
#(
    parameter int MAX_DIM = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    smm_item_if.sink      item,
    smm_result_if.source  result,
    smm_cfg_if.sink       cfg
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_ERR   = 2'd3;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] e;
        e = v;
        if (v == '0)
        begin
            e = DIM_W'(1);
        end
        else if (int'(v) > MAX_DIM)
        begin
            e = DIM_W'(MAX_DIM);
        end
        return e;
    endfunction

    logic [DIM_W-1:0]  rows_a_reg;
    logic [DIM_W-1:0]  cols_a_reg;
    logic [DIM_W-1:0]  rows_b_reg;
    logic [DIM_W-1:0]  cols_b_reg;
    logic [DIM_W-1:0]  ra;
    logic [DIM_W-1:0]  ca;
    logic [DIM_W-1:0]  rb;
    logic [DIM_W-1:0]  cb;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [DIM_W-1:0]  i_reg;
    logic [DIM_W-1:0]  i_next;
    logic [DIM_W-1:0]  j_reg;
    logic [DIM_W-1:0]  j_next;
    logic [DIM_W-1:0]  k_reg;
    logic [DIM_W-1:0]  k_next;

    logic              item_fire;
    logic              in_range;
    logic [AW-1:0]     wr_addr;
    logic              we_a;
    logic              we_b;
    logic              issue;
    logic [AW-1:0]     rd_a_addr;
    logic [AW-1:0]     rd_b_addr;
    logic [DATA_W-1:0] a_data;
    logic [DATA_W-1:0] b_data;
    mac_tag_t          tag;
    logic [DATA_W-1:0] acc;
    logic              mac_done;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              load_res;
    logic              res_err;
    logic              res_last;
    logic [IDX_W-1:0]  res_row;
    logic [IDX_W-1:0]  res_col;
    logic [DATA_W-1:0] res_value;
    logic [IDX_W-1:0]  out_row_reg;
    logic [IDX_W-1:0]  out_col_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_err_reg;
    logic              out_last_reg;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= DIM_RESET;
            cols_a_reg <= DIM_RESET;
            rows_b_reg <= DIM_RESET;
            cols_b_reg <= DIM_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ROWS_A: rows_a_reg <= cfg.data;
                CFG_COLS_A: cols_a_reg <= cfg.data;
                CFG_ROWS_B: rows_b_reg <= cfg.data;
                CFG_COLS_B: cols_b_reg <= cfg.data;
                default:    ;
            endcase
        end
    end

    assign ra = eff_dim(rows_a_reg);
    assign ca = eff_dim(cols_a_reg);
    assign rb = eff_dim(rows_b_reg);
    assign cb = eff_dim(cols_b_reg);

    // loads write the stores only while idle, reads happen only in a run
    assign item.ready = (state_reg == S_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign in_range   = (int'(item.row_index) < MAX_DIM) &&
                        (int'(item.col_index) < MAX_DIM);
    assign wr_addr    = AW'(int'(item.row_index) * MAX_DIM + int'(item.col_index));
    assign we_a       = item_fire && in_range && (item.action == ACT_LOAD_A);
    assign we_b       = item_fire && in_range && (item.action == ACT_LOAD_B);

    // read pair for inner term k of element (i, j)
    assign issue     = (state_reg == S_ISSUE) && ((k_reg != '0) || !out_valid_reg);
    assign rd_a_addr = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign rd_b_addr = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    assign tag.valid = issue;
    assign tag.first = (k_reg == '0);
    assign tag.last  = (k_reg == ca - DIM_W'(1));

    smm_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_first_store (
        .clk   (clk),
        .we    (we_a),
        .waddr (wr_addr),
        .wdata (item.element),
        .re    (issue),
        .raddr (rd_a_addr),
        .rdata (a_data)
    );

    smm_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_second_store (
        .clk   (clk),
        .we    (we_b),
        .waddr (wr_addr),
        .wdata (item.element),
        .re    (issue),
        .raddr (rd_b_addr),
        .rdata (b_data)
    );

    smm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag_in (tag),
        .a_data (a_data),
        .b_data (b_data),
        .acc    (acc),
        .done   (mac_done)
    );

    // sequencer over rows, columns and inner terms
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        load_res   = 1'b0;
        res_err    = 1'b0;
        res_last   = 1'b0;
        res_row    = i_reg[IDX_W-1:0];
        res_col    = j_reg[IDX_W-1:0];
        res_value  = acc;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire && (item.action == ACT_COMPUTE))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    state_next = (ca != rb) ? S_ERR : S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                if (issue)
                begin
                    if (tag.last)
                    begin
                        k_next     = '0;
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        k_next = k_reg + DIM_W'(1);
                    end
                end
            end
            S_DRAIN:
            begin
                if (mac_done)
                begin
                    load_res = 1'b1;
                    res_last = (i_reg == ra - DIM_W'(1)) && (j_reg == cb - DIM_W'(1));
                    if (j_reg == cb - DIM_W'(1))
                    begin
                        j_next     = '0;
                        i_next     = i_reg + DIM_W'(1);
                        state_next = res_last ? S_IDLE : S_ISSUE;
                    end
                    else
                    begin
                        j_next     = j_reg + DIM_W'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            S_ERR:
            begin
                if (!out_valid_reg)
                begin
                    load_res   = 1'b1;
                    res_err    = 1'b1;
                    res_last   = 1'b1;
                    res_row    = '0;
                    res_col    = '0;
                    res_value  = '0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // result register, loaded only when empty
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_res)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_row_reg   <= res_row;
            out_col_reg   <= res_col;
            out_value_reg <= res_value;
            out_err_reg   <= res_err;
            out_last_reg  <= res_last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.out_row       = out_row_reg;
    assign result.out_col       = out_col_reg;
    assign result.product_value = out_value_reg;
    assign result.dim_error     = out_err_reg;
    assign result.last          = out_last_reg;

endmodule

`default_nettype wire

// File: rtl/core/smm_checker.sv
// Port-level checks for the small matrix multiplier, bound to the top level.
// Depends on smm_pkg and small_matrix_multiply.
`default_nettype none

module smm_checker import smm_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     item_valid,
    input wire logic                     item_ready,
    input wire logic [ACT_W-1:0]         item_action,
    input wire logic                     result_valid,
    input wire logic                     result_ready,
    input wire logic [IDX_W-1:0]         result_out_row,
    input wire logic [IDX_W-1:0]         result_out_col,
    input wire logic signed [DATA_W-1:0] result_product_value,
    input wire logic                     result_dim_error,
    input wire logic                     result_last
);

    // a stalled result word holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(result_product_value) &&
            $stable(result_last) && $stable(result_dim_error))
        else $error("result word changed while stalled");

    // the mismatch word is a single zero word at the origin
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_dim_error |->
            result_last && (result_product_value == '0) &&
            (result_out_row == '0) && (result_out_col == '0))
        else $error("malformed dimension error word");

    // a compute word blocks further input words
    a_busy_after_compute: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_action == ACT_COMPUTE) |=> !item_ready)
        else $error("input taken right after a compute word");

    // the run is still busy after a word that is not the last
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_ready && !result_last |=> !item_ready)
        else $error("input taken before the run finished");

endmodule

bind small_matrix_multiply smm_checker u_smm_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .item_valid           (item.valid),
    .item_ready           (item.ready),
    .item_action          (item.action),
    .result_valid         (result.valid),
    .result_ready         (result.ready),
    .result_out_row       (result.out_row),
    .result_out_col       (result.out_col),
    .result_product_value (result.product_value),
    .result_dim_error     (result.dim_error),
    .result_last          (result.last)
);

`default_nettype wire
